// File: rtl/srgm_pkg.sv
// ============================================================================
// srgm_pkg
// Shared types, constants and helpers for the stereo gain ramp mixer.
// ============================================================================
package srgm_pkg;

    localparam int GAIN_W   = 17;
    localparam int LEN_W    = 13;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int ACC_W    = 32;
    localparam int SMP_W    = 16;
    localparam int FRAC_W   = 15;
    localparam int DIV_STEPS = ACC_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);
    localparam int PROD_W   = (SMP_W + 1) + ACC_W;

    localparam logic signed [SMP_W-1:0] MIX_SAT_POS = 16'sh7FFF;
    localparam logic signed [SMP_W-1:0] MIX_SAT_NEG = 16'sh8001;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT_START   = 3'd0,
        REG_RIGHT_START  = 3'd1,
        REG_LEFT_TARGET  = 3'd2,
        REG_RIGHT_TARGET = 3'd3,
        REG_RAMP_LENGTH  = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_ACC,
        ST_MUL_L,
        ST_MUL_R,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] source_sample;
        logic signed [SMP_W-1:0] mix_left;
        logic signed [SMP_W-1:0] mix_right;
        logic                    first_of_block;
    } sample_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] out_left;
        logic signed [SMP_W-1:0] out_right;
    } result_t;

    // Signed 16-bit add; on overflow clamp by the sign of the old mix word.
    function automatic logic signed [SMP_W-1:0] sat_add(
        input logic signed [SMP_W-1:0] old_word,
        input logic signed [SMP_W-1:0] term
    );
        logic signed [SMP_W:0] sum;
        begin
            sum = {old_word[SMP_W-1], old_word} + {term[SMP_W-1], term};
            if (sum[SMP_W] != sum[SMP_W-1])
            begin
                sat_add = old_word[SMP_W-1] ? MIX_SAT_NEG : MIX_SAT_POS;
            end
            else
            begin
                sat_add = sum[SMP_W-1:0];
            end
        end
    endfunction

endpackage

// File: rtl/srgm_stream_if.sv
// ============================================================================
// srgm_stream_if
// Valid/ready channel carrying one payload word per request.
// ============================================================================
interface srgm_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/stereo_gain_ramp_mixer.sv
// ============================================================================
// stereo_gain_ramp_mixer
// Mixes a mono voice into a stereo mix word pair with a linear gain ramp.
// ============================================================================
//
//  channel     dir   payload                                         accept
//  sample_ch   sink  source_sample, mix_left, mix_right, first_of_.. valid & ready
//  result_ch   src   out_left, out_right                             valid & ready
//  cfg         in    cfg_we, cfg_index, cfg_data                     cfg_we
//
//  A plain sample passes ST_ACC, ST_MUL_L, ST_MUL_R and ST_DONE before the
//  next acceptance: one shared 17x32 multiplier serves left then right.
//  A block start first runs ST_DIV_INIT and ST_DIV_RUN for each channel:
//  one shared radix-2 divider forms the gain step, left then right.
//  Reset clears gains, steps and accumulators; ramp_length resets to 1024.
//  A held result stalls the sequencer in its last step, and no new request
//  is taken until the sequencer is back in idle.
//
module stereo_gain_ramp_mixer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [srgm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srgm_pkg::CFG_W-1:0]       cfg_data,
    srgm_stream_if.sink                      sample_ch,
    srgm_stream_if.source                    result_ch
);
    import srgm_pkg::*;

    // configuration
    logic [GAIN_W-1:0] l_start_reg, r_start_reg, l_target_reg, r_target_reg;
    logic [LEN_W-1:0]  ramp_len_reg;

    // ramp state
    logic [ACC_W-1:0] l_acc_reg, l_acc_next, r_acc_reg, r_acc_next;
    logic [ACC_W-1:0] l_step_reg, l_step_next, r_step_reg, r_step_next;

    // sequencer
    state_t           state_reg, state_next;
    logic             div_ch_reg, div_ch_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // payload
    logic signed [SMP_W-1:0]  smp_reg, smp_next;
    logic signed [SMP_W-1:0]  mix_l_reg, mix_l_next, mix_r_reg, mix_r_next;
    logic signed [SMP_W-1:0]  res_l_reg, res_l_next;
    logic signed [SMP_W-1:0]  out_l_reg, out_l_next, out_r_reg, out_r_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [LEN_W-1:0]         rem_reg, rem_next;
    logic [ACC_W-1:0]         div_reg, div_next;
    logic                     neg_reg, neg_next;

    // shared units
    logic [LEN_W-1:0]         den;
    logic [GAIN_W-1:0]        sel_start, sel_target;
    logic signed [GAIN_W:0]   diff;
    logic [GAIN_W:0]          diff_mag;
    logic [LEN_W:0]           rem_shift;
    logic                     quo_bit;
    logic [ACC_W-1:0]         quo_final, step_value;
    logic signed [SMP_W:0]    mul_a;
    logic signed [ACC_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [SMP_W-1:0]  sum_word;
    logic signed [SMP_W-1:0]  sum_old;
    logic                     in_fire, out_free;

    assign den = (ramp_len_reg == '0) ? LEN_W'(1) : ramp_len_reg;

    // step numerator for the channel under division
    assign sel_start  = div_ch_reg ? r_start_reg  : l_start_reg;
    assign sel_target = div_ch_reg ? r_target_reg : l_target_reg;
    assign diff       = $signed({sel_target[GAIN_W-1], sel_target})
                      - $signed({sel_start[GAIN_W-1], sel_start});
    assign diff_mag   = diff[GAIN_W] ? (~diff + 1'b1) : diff;

    // one restoring division step
    assign rem_shift  = {rem_reg, div_reg[ACC_W-1]};
    assign quo_bit    = (rem_shift >= {1'b0, den});
    assign quo_final  = {div_reg[ACC_W-2:0], quo_bit};
    assign step_value = neg_reg ? (~quo_final + 1'b1) : quo_final;

    // one multiplier, left then right
    assign mul_a = $signed({smp_reg, 1'b0});
    assign mul_b = (state_reg == ST_MUL_L) ? $signed(l_acc_reg) : $signed(r_acc_reg);
    assign mul_p = mul_a * mul_b;

    // one saturating adder, left term in MUL_R, right term in DONE
    assign sum_old  = (state_reg == ST_MUL_R) ? mix_l_reg : mix_r_reg;
    assign sum_word = sat_add(sum_old, prod_reg[PROD_W-2 -: SMP_W]);

    assign sample_ch.ready = (state_reg == ST_IDLE);
    assign in_fire         = sample_ch.valid && (state_reg == ST_IDLE);
    assign out_free        = !out_valid_reg || result_ch.ready;

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.data.out_left  = out_l_reg;
    assign result_ch.data.out_right = out_r_reg;

    always_comb
    begin
        state_next     = state_reg;
        div_ch_next    = div_ch_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        l_acc_next     = l_acc_reg;
        r_acc_next     = r_acc_reg;
        l_step_next    = l_step_reg;
        r_step_next    = r_step_reg;
        smp_next       = smp_reg;
        mix_l_next     = mix_l_reg;
        mix_r_next     = mix_r_reg;
        res_l_next     = res_l_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        neg_next       = neg_reg;

        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    smp_next   = sample_ch.data.source_sample;
                    mix_l_next = sample_ch.data.mix_left;
                    mix_r_next = sample_ch.data.mix_right;
                    if (sample_ch.data.first_of_block)
                    begin
                        l_acc_next  = {l_start_reg, {FRAC_W{1'b0}}};
                        r_acc_next  = {r_start_reg, {FRAC_W{1'b0}}};
                        div_ch_next = 1'b0;
                        state_next  = ST_DIV_INIT;
                    end
                    else
                    begin
                        state_next = ST_ACC;
                    end
                end
            end
            ST_DIV_INIT:
            begin
                neg_next   = diff[GAIN_W];
                div_next   = {diff_mag[GAIN_W-1:0], {FRAC_W{1'b0}}};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                rem_next = quo_bit ? LEN_W'(rem_shift - {1'b0, den}) : rem_shift[LEN_W-1:0];
                div_next = quo_final;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    if (div_ch_reg)
                    begin
                        r_step_next = step_value;
                        state_next  = ST_ACC;
                    end
                    else
                    begin
                        l_step_next = step_value;
                        div_ch_next = 1'b1;
                        state_next  = ST_DIV_INIT;
                    end
                end
            end
            ST_ACC:
            begin
                l_acc_next = l_acc_reg + l_step_reg;
                r_acc_next = r_acc_reg + r_step_reg;
                state_next = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                prod_next  = mul_p;
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                res_l_next = sum_word;
                prod_next  = mul_p;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_l_next     = res_l_reg;
                    out_r_next     = sum_word;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_ch_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            l_acc_reg     <= '0;
            r_acc_reg     <= '0;
            l_step_reg    <= '0;
            r_step_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            div_ch_reg    <= div_ch_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            l_acc_reg     <= l_acc_next;
            r_acc_reg     <= r_acc_next;
            l_step_reg    <= l_step_next;
            r_step_reg    <= r_step_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l_start_reg  <= '0;
            r_start_reg  <= '0;
            l_target_reg <= '0;
            r_target_reg <= '0;
            ramp_len_reg <= LEN_W'(1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT_START:   l_start_reg  <= cfg_data[GAIN_W-1:0];
                REG_RIGHT_START:  r_start_reg  <= cfg_data[GAIN_W-1:0];
                REG_LEFT_TARGET:  l_target_reg <= cfg_data[GAIN_W-1:0];
                REG_RIGHT_TARGET: r_target_reg <= cfg_data[GAIN_W-1:0];
                REG_RAMP_LENGTH:  ramp_len_reg <= cfg_data[LEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg   <= smp_next;
        mix_l_reg <= mix_l_next;
        mix_r_reg <= mix_r_next;
        res_l_reg <= res_l_next;
        out_l_reg <= out_l_next;
        out_r_reg <= out_r_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        neg_reg   <= neg_next;
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_block_start_divides: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && sample_ch.data.first_of_block |=> state_reg == ST_DIV_INIT)
        else $error("block start did not enter the step division");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV_RUN |-> rem_reg < den)
        else $error("divider remainder not below divisor");

    a_cnt_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ACC |-> cnt_reg == '0)
        else $error("division counter not wrapped after division");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the final step");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives the stereo gain ramp mixer with mono samples and mix word pairs.
// Predicts the left and right mix words from the gain settings, the Q15 ramp
// accumulators and the saturating add, then checks each result in order.
// ============================================================================

class mix_scoreboard;

    logic signed [16:0] start_l, start_r, target_l, target_r;
    logic [12:0]        ramp_len;
    logic [31:0]        acc_l, acc_r, step_l, step_r;
    srgm_pkg::result_t  pending_mix[$];
    int                 errors;
    int                 samples;
    int                 block_starts;

    function new();
        start_l      = '0;
        start_r      = '0;
        target_l     = '0;
        target_r     = '0;
        ramp_len     = 13'd1024;
        acc_l        = '0;
        acc_r        = '0;
        step_l       = '0;
        step_r       = '0;
        errors       = 0;
        samples      = 0;
        block_starts = 0;
    endfunction

    function void write_reg(srgm_pkg::cfg_reg_t idx, logic [16:0] val);
        case (idx)
            srgm_pkg::REG_LEFT_START:   start_l  = val;
            srgm_pkg::REG_RIGHT_START:  start_r  = val;
            srgm_pkg::REG_LEFT_TARGET:  target_l = val;
            srgm_pkg::REG_RIGHT_TARGET: target_r = val;
            srgm_pkg::REG_RAMP_LENGTH:  ramp_len = val[12:0];
            default: ;
        endcase
    endfunction

    // Per-sample increment: ((target - start) << 15) / ramp_len, truncated toward zero.
    function logic [31:0] ramp_step(logic signed [16:0] from_gain,
                                    logic signed [16:0] to_gain);
        longint diff;
        longint den;
        longint quot;
        diff = longint'(to_gain) - longint'(from_gain);
        den  = (ramp_len == 13'd0) ? 64'sd1 : longint'(ramp_len);
        quot = (diff * 64'sd32768) / den;
        return quot[31:0];
    endfunction

    function logic signed [15:0] mix_channel(logic signed [15:0] smp,
                                             logic [31:0] acc,
                                             logic signed [15:0] old_word);
        longint             prod;
        logic signed [15:0] term;
        int                 sum;
        prod = (64'sd2 * longint'(smp)) * longint'($signed(acc));
        term = prod[47:32];
        sum  = int'(old_word) + int'(term);
        if (sum > 32767 || sum < -32768)
        begin
            return (old_word < 0) ? srgm_pkg::MIX_SAT_NEG : srgm_pkg::MIX_SAT_POS;
        end
        return sum[15:0];
    endfunction

    function void take_sample(srgm_pkg::sample_t s);
        srgm_pkg::result_t r;
        if (s.first_of_block)
        begin
            acc_l  = {start_l, 15'b0};
            acc_r  = {start_r, 15'b0};
            step_l = ramp_step(start_l, target_l);
            step_r = ramp_step(start_r, target_r);
            block_starts++;
        end
        // advance the ramp before the multiply, wrapping mod 2^32
        acc_l       = acc_l + step_l;
        acc_r       = acc_r + step_r;
        r.out_left  = mix_channel(s.source_sample, acc_l, s.mix_left);
        r.out_right = mix_channel(s.source_sample, acc_r, s.mix_right);
        pending_mix.push_back(r);
        samples++;
    endfunction

    function void check_mix(srgm_pkg::result_t got);
        srgm_pkg::result_t want;
        if (pending_mix.size() == 0)
        begin
            $error("result out_left=%0d out_right=%0d with no request pending",
                   got.out_left, got.out_right);
            errors++;
            return;
        end
        want = pending_mix.pop_front();
        if (got.out_left !== want.out_left)
        begin
            $error("out_left: expected %0d, got %0d", want.out_left, got.out_left);
            errors++;
        end
        if (got.out_right !== want.out_right)
        begin
            $error("out_right: expected %0d, got %0d", want.out_right, got.out_right);
            errors++;
        end
    endfunction

endclass

module testbench;

    import srgm_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    srgm_stream_if #(.payload_t(sample_t)) sample_ch ();
    srgm_stream_if #(.payload_t(result_t)) result_ch ();

    mix_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int settings      = 0;

    stereo_gain_ramp_mixer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample_ch (sample_ch),
        .result_ch (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("stereo_gain_ramp_mixer: mismatch");
        $finish;
    end

    always @(negedge clk)
    begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            sb.check_mix(result_ch.data);
        end
    end

    function automatic sample_t mk_sample(int smp, int ml, int mr, bit first);
        sample_t s;
        s.source_sample  = 16'(smp);
        s.mix_left       = 16'(ml);
        s.mix_right      = 16'(mr);
        s.first_of_block = first;
        return s;
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(7))
            0: return -65536;
            1: return 65535;
            2: return -65535;
            3: return 0;
            default: return int'($urandom_range(131071)) - 65536;
        endcase
    endfunction

    function automatic int pick_len();
        case ($urandom_range(7))
            0: return 0;
            1: return 1;
            2: return 8191;
            3: return 4096;
            4: return 1024;
            default: return int'($urandom_range(2, 300));
        endcase
    endfunction

    function automatic int pick_word();
        case ($urandom_range(9))
            0: return -32768;
            1: return 32767;
            2: return 0;
            3: return -1;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // Write all five registers, one per cycle; called only with nothing in flight.
    task automatic load_gains(input int ls, input int rs, input int lt, input int rt,
                              input int len);
        cfg_reg_t idx[5];
        int       val[5];
        idx = '{REG_LEFT_START, REG_RIGHT_START, REG_LEFT_TARGET, REG_RIGHT_TARGET,
                REG_RAMP_LENGTH};
        val = '{ls, rs, lt, rt, len};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= 17'(val[i]);
            sb.write_reg(idx[i], 17'(val[i]));
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        settings++;
    endtask

    // Enter and leave at a falling edge; valid stays up until the next call or drain.
    task automatic send_sample(input sample_t s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data  <= s;
        do @(posedge clk); while (!sample_ch.ready);
        sb.take_sample(s);
        @(negedge clk);
    endtask

    // Drop valid and hold until every request has produced its result.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        while (sb.pending_mix.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        int      sent;
        int      phase_items;
        int      ls;
        int      rs;
        sample_t s;

        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_LEFT_START;
        cfg_data        <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.data  <= '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 9;
        recv_idle_pct = 45;

        // no block start yet: zero gain passes the mix words through
        send_sample(mk_sample(32767, -32768, 32767, 1'b0));
        send_sample(mk_sample(-32768, 32767, -32768, 1'b0));
        drain();

        // constant gain at the extremes, with saturation both ways
        load_gains(65535, -65536, 65535, -65536, 1);
        send_sample(mk_sample(32767, 32767, 32767, 1'b1));
        send_sample(mk_sample(-32768, -32768, -32768, 1'b0));
        send_sample(mk_sample(-32768, 32767, 0, 1'b0));
        send_sample(mk_sample(-1, 0, -1, 1'b0));
        send_sample(mk_sample(0, -32768, 32767, 1'b0));
        drain();

        // full-scale step wraps, and the accumulators wrap as they advance
        load_gains(-65536, 65535, 65535, -65536, 1);
        send_sample(mk_sample(12345, 100, -100, 1'b1));
        send_sample(mk_sample(-32768, 0, 0, 1'b0));
        send_sample(mk_sample(32767, -5, 5, 1'b0));
        send_sample(mk_sample(-20000, 32000, -32000, 1'b0));
        send_sample(mk_sample(30000, -1, 1, 1'b0));
        drain();

        // zero ramp length divides by one
        load_gains(0, -300, 100, 300, 0);
        send_sample(mk_sample(32767, 1000, -1000, 1'b1));
        send_sample(mk_sample(-32768, 0, 0, 1'b0));
        send_sample(mk_sample(16384, 0, 0, 1'b0));
        drain();

        load_gains(40000, -40000, -65535, 65535, 8191);
        send_sample(mk_sample(32767, 0, 0, 1'b1));
        send_sample(mk_sample(-32768, 0, 0, 1'b0));
        send_sample(mk_sample(21845, -21846, 21845, 1'b0));
        drain();

        sent = 0;
        while (sent < 1200)
        begin
            ls = pick_gain();
            rs = pick_gain();
            // equal start and target exercises the constant-gain path
            load_gains(ls, rs,
                       ($urandom_range(3) == 0) ? ls : pick_gain(),
                       ($urandom_range(3) == 0) ? rs : pick_gain(),
                       pick_len());
            phase_items = $urandom_range(40, 120);
            for (int i = 0; i < phase_items; i++)
            begin
                if (sent < 400)
                begin
                    send_idle_pct = 9;
                    recv_idle_pct = 45;
                end
                else if (sent < 800)
                begin
                    send_idle_pct = 45;
                    recv_idle_pct = 9;
                end
                else
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                s = mk_sample(pick_word(), pick_word(), pick_word(),
                              (i == 0) ? ($urandom_range(7) != 0)
                                       : ($urandom_range(15) == 0));
                send_sample(s);
                sent++;
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (sb.pending_mix.size() != 0)
        begin
            $error("%0d results never arrived", sb.pending_mix.size());
            sb.errors++;
        end
        $display("Mixed %0d samples under %0d gain settings, %0d of them block starts,",
                 sb.samples, settings, sb.block_starts);
        $display("with sender and receiver stalls swapped between the first two thirds.");
        if (sb.errors == 0)
        begin
            $display("stereo_gain_ramp_mixer: match");
        end
        else
        begin
            $display("stereo_gain_ramp_mixer: mismatch");
        end
        $finish;
    end

endmodule

// File: stereo_gain_ramp_mixer.f
rtl/srgm_pkg.sv
rtl/srgm_stream_if.sv
rtl/stereo_gain_ramp_mixer.sv
tb/sv/testbench.sv
